[hw/rtl/ill_pkg.sv]
// shared types and constants for the inline line layout block
package ill_pkg;

	localparam int LINE_FRAGS = 32;
	localparam int FIDX_W = $clog2(LINE_FRAGS);
	localparam int FCNT_W = $clog2(LINE_FRAGS + 1);
	localparam int QDEPTH = 2;
	localparam int PL_W = 40;
	localparam int SH_W = 50;

	localparam logic OP_RUN = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [1:0] VA_BASE = 2'd0;
	localparam logic [1:0] VA_TOP = 2'd1;
	localparam logic [1:0] VA_MID = 2'd2;
	localparam logic [1:0] VA_BOT = 2'd3;

	localparam logic CFG_MAX_WIDTH = 1'b0;
	localparam logic CFG_START_X = 1'b1;

	typedef struct packed {
		logic        op;
		logic [15:0] run_width;
		logic [15:0] run_height;
		logic [15:0] run_asc;
		logic [1:0]  valign;
	} in_item_t;

	typedef struct packed {
		logic [15:0] run_number;
		logic [15:0] line_number;
		logic [23:0] frag_x;
		logic [23:0] frag_y;
		logic [15:0] frag_width;
		logic [15:0] frag_height;
		logic [15:0] frag_ascent;
		logic [16:0] line_total_height;
		logic        line_end;
	} out_item_t;

	// classified command passed from front to back
	typedef struct packed {
		logic        flush;
		logic        wrap;
		logic [23:0] frag_x;
		logic [15:0] run_number;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] ascent;
		logic [1:0]  valign;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_LAST
	} back_state_t;

	function automatic logic [15:0] resolve_asc(input logic [15:0] h, input logic [15:0] a);
		logic [15:0] lim;
		begin
			lim = (h != '0) ? h : a;
			if (a == '0) return h;
			return (a < lim) ? a : lim;
		end
	endfunction

	function automatic logic [23:0] sat24(input logic [24:0] v);
		return v[24] ? 24'hFFFFFF : v[23:0];
	endfunction

endpackage

[hw/rtl/ill_front.sv]
// front end: cursor tracking, wrap decision, command generation
module ill_front import ill_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  in_item_t    in_item,
	output logic        in_stall,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [23:0] cfg_data,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_full
);
	logic [23:0] max_width_q, start_x_q, cursor_x_q;
	logic [15:0] run_counter_q;
	logic        line_open_q;
	logic [FCNT_W-1:0] frag_count_q;
	logic        wrap;
	logic [24:0] sum_x;

	assign in_stall = cmd_full;
	assign sum_x = {1'b0, cursor_x_q} + {9'd0, in_item.run_width};
	assign wrap = line_open_q && (((max_width_q != '0) && (cursor_x_q != '0) &&
		(sum_x > {1'b0, max_width_q})) || (frag_count_q >= FCNT_W'(LINE_FRAGS)));

	always_comb begin
		cmd.flush = (in_item.op == OP_FLUSH);
		cmd.wrap = (in_item.op == OP_FLUSH) ? line_open_q : wrap;
		cmd.frag_x = wrap ? '0 : cursor_x_q;
		cmd.run_number = run_counter_q;
		cmd.width = in_item.run_width;
		cmd.height = in_item.run_height;
		cmd.ascent = resolve_asc(in_item.run_height, in_item.run_asc);
		cmd.valign = in_item.valign;
	end
	assign cmd_valid = in_valid && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q <= '0;
			start_x_q <= '0;
			cursor_x_q <= '0;
			run_counter_q <= '0;
			line_open_q <= 1'b0;
			frag_count_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_MAX_WIDTH) max_width_q <= cfg_data;
				else begin
					start_x_q <= cfg_data;
					if (!line_open_q) cursor_x_q <= cfg_data;
				end
			end
			if (cmd_valid) begin
				if (in_item.op == OP_FLUSH) begin
					cursor_x_q <= start_x_q;
					run_counter_q <= '0;
					line_open_q <= 1'b0;
					frag_count_q <= '0;
				end else begin
					line_open_q <= 1'b1;
					run_counter_q <= run_counter_q + 16'd1;
					if (wrap) begin
						cursor_x_q <= {8'd0, in_item.run_width};
						frag_count_q <= FCNT_W'(1);
					end else begin
						cursor_x_q <= sat24(sum_x);
						frag_count_q <= frag_count_q + FCNT_W'(1);
					end
				end
			end
		end
	end
endmodule

[hw/rtl/ill_queue.sv]
// short command queue between front and back
module ill_queue import ill_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t pop_data
);
	cmd_t mem_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(QDEPTH+1)-1:0] cnt_q;

	assign full = (cnt_q == ($clog2(QDEPTH+1))'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + ($clog2(QDEPTH+1))'(push) - ($clog2(QDEPTH+1))'(pop);
		end
	end
endmodule

[hw/rtl/ill_back.sv]
// back end: fragment buffer, line metrics, line emission
module ill_back import ill_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        out_valid,
	output out_item_t   out_item,
	input  logic        out_stall,
	output logic        busy
);
	logic [PL_W-1:0] place_mem [LINE_FRAGS];
	logic [SH_W-1:0] shape_mem [LINE_FRAGS];
	logic [PL_W-1:0] place_rd_q;
	logic [SH_W-1:0] shape_rd_q;

	back_state_t state_q, state_d;
	logic [FCNT_W-1:0] count_q, rd_q;
	logic [FIDX_W-1:0] wr_idx;
	logic [15:0] max_asc_q, max_desc_q, line_ctr_q;
	logic [23:0] cursor_y_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        out_free;
	logic        start_emit, rd_en, emit_fire;
	logic [15:0] rd_desc;
	logic [16:0] lh, slack;
	logic [15:0] va_off;
	logic [24:0] y;

	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign busy = (state_q != ST_IDLE) || out_valid_q;

	// pending command needs emission first when it closes a nonempty line
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		start_emit = 1'b0;
		rd_en = 1'b0;
		emit_fire = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (q_cmd.wrap && count_q != '0) begin
						start_emit = 1'b1;
						rd_en = 1'b1;
						state_d = ST_EMIT;
					end else begin
						q_pop = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_fire = 1'b1;
					if (rd_q == count_q) state_d = ST_LAST;
					else rd_en = 1'b1;
				end
			end
			ST_LAST: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign lh = {1'b0, max_asc_q} + {1'b0, max_desc_q};
	always_comb begin
		slack = (lh > {1'b0, shape_rd_q[31:16]}) ? lh - {1'b0, shape_rd_q[31:16]} : '0;
		case (shape_rd_q[49:48])
			VA_TOP: va_off = '0;
			VA_MID: va_off = slack[16:1];
			VA_BOT: va_off = '0;
			default: va_off = (max_asc_q > shape_rd_q[47:32]) ?
				max_asc_q - shape_rd_q[47:32] : '0;
		endcase
		if (shape_rd_q[49:48] == VA_BOT)
			y = {1'b0, cursor_y_q} + {8'd0, slack};
		else
			y = {1'b0, cursor_y_q} + {9'd0, va_off};
	end

	assign rd_desc = (q_cmd.height > q_cmd.ascent) ? q_cmd.height - q_cmd.ascent : '0;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			place_rd_q <= place_mem[start_emit ? '0 : rd_q[FIDX_W-1:0]];
			shape_rd_q <= shape_mem[start_emit ? '0 : rd_q[FIDX_W-1:0]];
		end
		if (q_pop && !q_cmd.flush)
			place_mem[wr_idx] <= {q_cmd.run_number, q_cmd.frag_x};
		if (q_pop && !q_cmd.flush)
			shape_mem[wr_idx] <= {q_cmd.valign, q_cmd.ascent, q_cmd.height, q_cmd.width};
		if (emit_fire) begin
			out_q.run_number <= place_rd_q[39:24];
			out_q.line_number <= line_ctr_q;
			out_q.frag_x <= place_rd_q[23:0];
			out_q.frag_y <= sat24(y);
			out_q.frag_width <= shape_rd_q[15:0];
			out_q.frag_height <= shape_rd_q[31:16];
			out_q.frag_ascent <= shape_rd_q[47:32];
			out_q.line_total_height <= lh;
			out_q.line_end <= (rd_q == count_q);
		end
	end

	// write index of the next fragment: zero once a wrap has been emitted
	always_comb wr_idx = (q_cmd.wrap) ? '0 : count_q[FIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_q <= '0;
			max_asc_q <= '0;
			max_desc_q <= '0;
			line_ctr_q <= '0;
			cursor_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_emit) rd_q <= FCNT_W'(1);
			else if (rd_en) rd_q <= rd_q + FCNT_W'(1);
			if (emit_fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			// line closed: drop count so the queued command pops next
			if (state_q == ST_LAST) begin
				count_q <= '0;
			end
			if (q_pop) begin
				if (q_cmd.flush) begin
					count_q <= '0;
					max_asc_q <= '0;
					max_desc_q <= '0;
					line_ctr_q <= '0;
					cursor_y_q <= '0;
				end else if (q_cmd.wrap) begin
					cursor_y_q <= sat24({1'b0, cursor_y_q} + {8'd0, lh});
					line_ctr_q <= line_ctr_q + 16'd1;
					count_q <= FCNT_W'(1);
					max_asc_q <= q_cmd.ascent;
					max_desc_q <= rd_desc;
				end else begin
					count_q <= count_q + FCNT_W'(1);
					if (q_cmd.ascent > max_asc_q) max_asc_q <= q_cmd.ascent;
					if (rd_desc > max_desc_q) max_desc_q <= rd_desc;
				end
			end
		end
	end
endmodule

[hw/rtl/inline_line_layout_top.sv]
// top level of the greedy inline line breaker
// emission: a beat that closes a line passes the queue, the fragment buffer read register and
//   the output register before its first fragment, then one fragment per unstalled cycle
// throughput: one run per cycle while no line closes; a closed line holds the back end while
//   its fragments are read out through the single read port of the fragment buffer
// reset: arst_n clears all cursors, counters and the queue; buffer contents stay undefined
module inline_line_layout_top import ill_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  in_item_t    in_data,
	output logic        in_stall,
	output logic        out_valid,
	output out_item_t   out_data,
	input  logic        out_stall,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	// front to queue
	logic cmd_valid, q_full, q_empty, q_pop, back_busy;
	cmd_t cmd, q_cmd;
	logic cfg_we;

	// configuration is always taken; writes arrive only when idle is a rule for the user, not enforced here
	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	ill_front u_front (
		.clk, .arst_n,
		.in_valid, .in_item(in_data), .in_stall,
		.cfg_we, .cfg_idx(cfg_index[0]), .cfg_data,
		.cmd_valid, .cmd, .cmd_full(q_full)
	);

	// decoupling queue buffers up to QDEPTH front commands, the closing one included, while back emits a line
	ill_queue u_queue (
		.clk, .arst_n,
		.push(cmd_valid), .push_data(cmd), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_data(q_cmd)
	);

	ill_back u_back (
		.clk, .arst_n,
		.q_empty, .q_cmd, .q_pop,
		.out_valid, .out_item(out_data), .out_stall,
		.busy(back_busy)
	);

	// a stalled result beat must hold its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed under stall");

	// no pop from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("queue underflow");

	// no push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) cmd_valid |-> !q_full)
		else $error("queue overflow");

	// a pending result beat keeps the back end busy
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> back_busy)
		else $error("result beat while back end idle");
endmodule
